// File: src/wpf_pkg.sv
package wpf_pkg;

	typedef enum logic [1:0] {
		MODE_ROT    = 2'd0,
		MODE_FOLLOW = 2'd1,
		MODE_DONE   = 2'd2
	} mode_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_START_A, ST_START_B, ST_HEAD, ST_ROT, ST_ROT_MUL,
		ST_F_YAW, ST_F_TX, ST_F_TY, ST_F_DOT1, ST_F_DOT2, ST_F_DECIDE,
		ST_F_FINAL, ST_F_ADV, ST_F_SEG, ST_F_TS, ST_F_CS, ST_F_D1, ST_F_D2,
		ST_F_ERR, ST_F_CHK, ST_F_NUM, ST_F_DEN, ST_F_DIV, ST_F_T2, ST_EMIT
	} state_t;

	localparam logic [1:0] REQ_LOAD  = 2'd0;
	localparam logic [1:0] REQ_START = 2'd1;
	localparam logic [1:0] REQ_TICK  = 2'd2;

	localparam logic [2:0] REG_FWD_SPEED = 3'd0;
	localparam logic [2:0] REG_LOOKAHEAD = 3'd1;
	localparam logic [2:0] REG_ROT_GAIN  = 3'd2;
	localparam logic [2:0] REG_ANG_LIMIT = 3'd3;
	localparam logic [2:0] REG_HEAD_TOL  = 3'd4;

	localparam int CW = 40;
	localparam int ZW = 36;
	localparam logic signed [ZW-1:0] Q30_PI      = 36'sd3373259426;
	localparam logic signed [ZW-1:0] Q30_HALF_PI = 36'sd1686629713;
	localparam logic signed [ZW-1:0] Q30_TWO_PI  = 36'sd6746518852;
	localparam logic signed [CW-1:0] Q30_GAIN    = 40'sd652032874;

	typedef struct packed {
		logic                  start;
		logic                  vec;
		logic signed [CW-1:0]  x;
		logic signed [CW-1:0]  y;
		logic signed [ZW-1:0]  z;
	} cordic_req_t;

	typedef struct packed {
		logic               start;
		logic               div;
		logic signed [63:0] a;
		logic signed [63:0] b;
	} muldiv_req_t;

	function automatic logic [29:0] atan_q30(input logic [4:0] i);
		logic [29:0] r;
		case (i)
			5'd0: r = 30'd843314857;
			5'd1: r = 30'd497837830;
			5'd2: r = 30'd263043837;
			5'd3: r = 30'd133525159;
			5'd4: r = 30'd67021688;
			5'd5: r = 30'd33543515;
			5'd6: r = 30'd16775850;
			5'd7: r = 30'd8388438;
			5'd8: r = 30'd4194283;
			5'd9: r = 30'd2097150;
			5'd10: r = 30'd1048576;
			5'd11: r = 30'd524288;
			5'd12: r = 30'd262144;
			5'd13: r = 30'd131072;
			5'd14: r = 30'd65536;
			5'd15: r = 30'd32768;
			5'd16: r = 30'd16384;
			5'd17: r = 30'd8192;
			5'd18: r = 30'd4096;
			5'd19: r = 30'd2048;
			5'd20: r = 30'd1024;
			5'd21: r = 30'd512;
			5'd22: r = 30'd256;
			5'd23: r = 30'd128;
			5'd24: r = 30'd64;
			5'd25: r = 30'd32;
			5'd26: r = 30'd16;
			5'd27: r = 30'd8;
			5'd28: r = 30'd4;
			5'd29: r = 30'd2;
			5'd30: r = 30'd1;
			default: r = 30'd0;
		endcase
		return r;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647) begin
			r = 32'sh7FFFFFFF;
		end else if (v < -64'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	function automatic logic signed [31:0] clamp_lim(input logic signed [63:0] v,
		input logic [30:0] lim);
		logic signed [63:0] l;
		logic signed [31:0] r;
		l = {33'd0, lim};
		if (v > l) begin
			r = l[31:0];
		end else if (v < -l) begin
			r = 32'(-l);
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

// File: src/wpf_ram.sv
module wpf_ram #(
	parameter int WIDTH = 80,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

// File: src/wpf_cordic.sv
module wpf_cordic #(
	parameter int STEPS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  wpf_pkg::cordic_req_t                req,
	output logic signed [wpf_pkg::CW-1:0]       x_o,
	output logic signed [wpf_pkg::CW-1:0]       y_o,
	output logic signed [wpf_pkg::ZW-1:0]       z_o,
	output logic                                done
);
	logic signed [wpf_pkg::CW-1:0] x_q, y_q, dx, dy;
	logic signed [wpf_pkg::ZW-1:0] z_q, at;
	logic       neg_q, vec_q, busy_q, red_q, done_q;
	logic [5:0] i_q;
	logic       ccw;

	assign dx  = y_q >>> i_q[4:0];
	assign dy  = x_q >>> i_q[4:0];
	assign at  = {6'd0, wpf_pkg::atan_q30(i_q[4:0])};
	assign ccw = vec_q ? !(y_q > 0) : (z_q >= 0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			red_q  <= 1'b0;
			done_q <= 1'b0;
			neg_q  <= 1'b0;
			vec_q  <= 1'b0;
			i_q    <= '0;
			x_q    <= '0;
			y_q    <= '0;
			z_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				neg_q  <= 1'b0;
				vec_q  <= req.vec;
				i_q    <= '0;
				if (req.vec) begin
					red_q <= 1'b0;
					if (req.x < 0) begin
						x_q <= -req.x;
						y_q <= -req.y;
						z_q <= (req.y >= 0) ? wpf_pkg::Q30_PI : -wpf_pkg::Q30_PI;
					end else begin
						x_q <= req.x;
						y_q <= req.y;
						z_q <= '0;
					end
				end else begin
					red_q <= 1'b1;
					x_q   <= wpf_pkg::Q30_GAIN;
					y_q   <= '0;
					z_q   <= req.z;
				end
			end else if (busy_q && red_q) begin
				if (z_q > wpf_pkg::Q30_PI) begin
					z_q <= z_q - wpf_pkg::Q30_TWO_PI;
				end else if (z_q < -wpf_pkg::Q30_PI) begin
					z_q <= z_q + wpf_pkg::Q30_TWO_PI;
				end else begin
					red_q <= 1'b0;
					if (z_q > wpf_pkg::Q30_HALF_PI) begin
						z_q   <= z_q - wpf_pkg::Q30_PI;
						neg_q <= 1'b1;
					end else if (z_q < -wpf_pkg::Q30_HALF_PI) begin
						z_q   <= z_q + wpf_pkg::Q30_PI;
						neg_q <= 1'b1;
					end
				end
			end else if (busy_q) begin
				if (ccw) begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - at;
				end else begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + at;
				end
				i_q <= i_q + 6'd1;
				if (i_q == 6'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign x_o  = neg_q ? -x_q : x_q;
	assign y_o  = neg_q ? -y_q : y_q;
	assign z_o  = z_q;
	assign done = done_q;
endmodule

// File: src/wpf_muldiv.sv
module wpf_muldiv (
	input  logic                 clk,
	input  logic                 arst_n,
	input  wpf_pkg::muldiv_req_t req,
	output logic signed [63:0]   result,
	output logic                 done
);
	logic [63:0] acc_q, am_q, bm_q, rem_n;
	logic        sign_q, div_q, busy_q, done_q;
	logic [5:0]  cnt_q;
	logic        fits;

	assign rem_n = {acc_q[62:0], am_q[63]};
	assign fits  = rem_n >= bm_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			sign_q <= 1'b0;
			div_q  <= 1'b0;
			cnt_q  <= '0;
			acc_q  <= '0;
			am_q   <= '0;
			bm_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				sign_q <= req.a[63] ^ req.b[63];
				div_q  <= req.div;
				cnt_q  <= '0;
				acc_q  <= '0;
				am_q   <= req.a[63] ? -req.a : req.a;
				bm_q   <= req.b[63] ? -req.b : req.b;
			end else if (busy_q && !div_q) begin
				if (bm_q == 64'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					if (bm_q[0]) begin
						acc_q <= acc_q + am_q;
					end
					am_q <= {am_q[62:0], 1'b0};
					bm_q <= {1'b0, bm_q[63:1]};
				end
			end else if (busy_q) begin
				acc_q <= fits ? rem_n - bm_q : rem_n;
				am_q  <= {am_q[62:0], fits};
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_comb begin
		if (div_q) begin
			result = sign_q ? -am_q : am_q;
		end else begin
			result = sign_q ? -acc_q : acc_q;
		end
	end

	assign done = done_q;
endmodule

// File: src/waypoint_path_follower_core.sv
// Lookahead path-following controller for a differential robot.
// Requests arrive on the s_ stream: tuser carries the request kind (load a
// waypoint, start a plan, control tick) and tdata the slot, pose or waypoint
// and the plan length. Every request yields exactly one command on the m_
// stream: linear and angular rate, a validity flag, the mode, a goal flag and
// the current waypoint index. Gains and limits are set through the cfg_ port.
// The block takes one request at a time; s_tready is high only while idle.
// A tick while following runs four CORDIC passes, up to nine serial
// multiplies and one division on one shared multiply/divide unit.
// A finished command waits in the output register; the next request is
// taken meanwhile, and only its own result waits for m_tready.
// Reset puts the plan in the done state with default gains; the waypoint
// table is not cleared and must be loaded before a plan is started.
module waypoint_path_follower_core #(
	parameter int MAX_POINTS   = 64,
	parameter int CORDIC_STEPS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// slot, pos_x, pos_y, heading, point_count
	input  logic [95:0] s_tdata,
	// req_type
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// linear_rate, angular_rate, command_ok, mode, goal_reached, point_index
	output logic [79:0] m_tdata,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [30:0] cfg_data
);
	localparam int NPW = $clog2(MAX_POINTS);
	localparam int PLW = $clog2(MAX_POINTS + 1);

	wpf_pkg::state_t state_q, state_d;
	wpf_pkg::mode_t  mode_q;

	logic [30:0] speed_q, la_q, gain_q, lim_q;
	logic [14:0] tol_q;

	logic signed [31:0] px_q, py_q, sx_q, sy_q, ex_q, ey_q, tx_q, ty_q, d_q;
	logic signed [15:0] yaw_q, th_q;
	logic [NPW-1:0]     np_q;
	logic [PLW-1:0]     pl_q;
	logic signed [63:0] prod_q, num_q, den_q, t1_q;
	logic signed [wpf_pkg::ZW-1:0] ts_q;
	logic               dot_pos_q, go_q;
	logic [30:0]        lin_q;
	logic signed [31:0] ang_q;
	logic               ok_q;
	logic               m_valid_q;
	logic [79:0]        out_q;

	logic [1:0]         in_req;
	logic [5:0]         in_slot;
	logic [6:0]         in_count;
	logic               accept, slot_ok, count_ok, last_seg, fin, issue;

	logic signed [63:0] l1_w, speed_w, vx_w, vy_w, c15_w, s15_w, t2_w, ang_raw;
	logic signed [16:0] err_w, aerr_w;
	logic signed [wpf_pkg::ZW-1:0] yawz_w, hz_w;

	wpf_pkg::cordic_req_t cd_req;
	wpf_pkg::muldiv_req_t md_req;
	logic signed [wpf_pkg::CW-1:0] cd_x, cd_y;
	logic signed [wpf_pkg::ZW-1:0] cd_z;
	logic signed [63:0] md_res;
	logic               cd_done, md_done;

	logic               ram_we;
	logic [NPW-1:0]     ram_raddr;
	logic [79:0]        ram_rdata;

	assign in_req   = s_tuser;
	assign in_slot  = s_tdata[5:0];
	assign in_count = s_tdata[92:86];
	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == wpf_pkg::ST_IDLE);
	assign slot_ok  = {26'd0, in_slot} < MAX_POINTS;
	assign count_ok = ({25'd0, in_count} >= 32'd2) && ({25'd0, in_count} <= MAX_POINTS);
	assign ram_we   = accept && (in_req == wpf_pkg::REQ_LOAD) && slot_ok;
	assign last_seg = !((PLW + 1)'(np_q) + (PLW + 1)'(1) < (PLW + 1)'(pl_q));
	assign fin      = go_q && (cd_done || md_done);

	assign l1_w    = {33'd0, (la_q == 31'd0) ? 31'd1 : la_q};
	assign speed_w = {33'd0, speed_q};
	assign vx_w    = 64'(ex_q) - 64'(sx_q);
	assign vy_w    = 64'(ey_q) - 64'(sy_q);
	assign c15_w   = 64'(cd_x >>> 15);
	assign s15_w   = 64'(cd_y >>> 15);
	assign t2_w    = ((md_res >>> 16) <<< 3) + ((md_res >>> 16) <<< 1);
	assign ang_raw = (c15_w > 0) ? (-t1_q - t2_w) : (t2_w - t1_q);
	assign err_w   = 17'(th_q) - 17'(yaw_q);
	assign aerr_w  = err_w[16] ? -err_w : err_w;
	assign yawz_w  = wpf_pkg::ZW'(yaw_q) <<< 18;
	assign hz_w    = cd_z + 36'sd131072;

	wpf_ram #(.WIDTH(80), .DEPTH(MAX_POINTS)) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (NPW'(in_slot)),
		.wdata ({s_tdata[85:70], s_tdata[69:38], s_tdata[37:6]}),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	wpf_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (cd_req),
		.x_o    (cd_x),
		.y_o    (cd_y),
		.z_o    (cd_z),
		.done   (cd_done)
	);

	wpf_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (md_req),
		.result (md_res),
		.done   (md_done)
	);

	always_comb begin
		state_d   = state_q;
		issue     = !go_q;
		ram_raddr = '0;
		cd_req    = '0;
		md_req    = '0;
		case (state_q)
			wpf_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = wpf_pkg::ST_EMIT;
					if (in_req == wpf_pkg::REQ_START && count_ok) begin
						state_d = wpf_pkg::ST_START_A;
					end else if (in_req == wpf_pkg::REQ_TICK) begin
						if (mode_q == wpf_pkg::MODE_ROT) begin
							state_d = wpf_pkg::ST_ROT;
						end else if (mode_q == wpf_pkg::MODE_FOLLOW) begin
							state_d = wpf_pkg::ST_F_YAW;
						end
					end
				end
			end
			wpf_pkg::ST_START_A: begin
				ram_raddr = NPW'(1);
				state_d   = wpf_pkg::ST_START_B;
			end
			wpf_pkg::ST_START_B: begin
				state_d = wpf_pkg::ST_HEAD;
			end
			wpf_pkg::ST_HEAD, wpf_pkg::ST_F_TS: begin
				cd_req.start = issue;
				cd_req.vec   = 1'b1;
				cd_req.x     = wpf_pkg::CW'(vx_w);
				cd_req.y     = wpf_pkg::CW'(vy_w);
				if (fin) begin
					state_d = (state_q == wpf_pkg::ST_HEAD) ? wpf_pkg::ST_EMIT
						: wpf_pkg::ST_F_CS;
				end
			end
			wpf_pkg::ST_ROT: begin
				state_d = (aerr_w < 17'sd0 + $signed({2'b0, tol_q})) ? wpf_pkg::ST_EMIT
					: wpf_pkg::ST_ROT_MUL;
			end
			wpf_pkg::ST_ROT_MUL: begin
				md_req.start = issue;
				md_req.a     = {33'd0, gain_q};
				md_req.b     = 64'(err_w);
				if (fin) begin
					state_d = wpf_pkg::ST_EMIT;
				end
			end
			wpf_pkg::ST_F_YAW: begin
				cd_req.start = issue;
				cd_req.z     = yawz_w;
				if (fin) begin
					state_d = wpf_pkg::ST_F_TX;
				end
			end
			wpf_pkg::ST_F_TX: begin
				md_req.start = issue;
				md_req.a     = l1_w;
				md_req.b     = 64'(cd_x);
				if (fin) begin
					state_d = wpf_pkg::ST_F_TY;
				end
			end
			wpf_pkg::ST_F_TY: begin
				md_req.start = issue;
				md_req.a     = l1_w;
				md_req.b     = 64'(cd_y);
				if (fin) begin
					state_d = wpf_pkg::ST_F_DOT1;
				end
			end
			wpf_pkg::ST_F_DOT1: begin
				md_req.start = issue;
				md_req.a     = vx_w >>> 3;
				md_req.b     = (64'(tx_q) - 64'(ex_q)) >>> 3;
				if (fin) begin
					state_d = wpf_pkg::ST_F_DOT2;
				end
			end
			wpf_pkg::ST_F_DOT2: begin
				md_req.start = issue;
				md_req.a     = vy_w >>> 3;
				md_req.b     = (64'(ty_q) - 64'(ey_q)) >>> 3;
				if (fin) begin
					state_d = wpf_pkg::ST_F_DECIDE;
				end
			end
			wpf_pkg::ST_F_DECIDE: begin
				if (dot_pos_q && last_seg) begin
					ram_raddr = np_q;
					state_d   = wpf_pkg::ST_F_FINAL;
				end else if (dot_pos_q) begin
					ram_raddr = np_q + NPW'(1);
					state_d   = wpf_pkg::ST_F_ADV;
				end else begin
					state_d = wpf_pkg::ST_F_SEG;
				end
			end
			wpf_pkg::ST_F_FINAL: begin
				state_d = wpf_pkg::ST_EMIT;
			end
			wpf_pkg::ST_F_ADV: begin
				state_d = wpf_pkg::ST_F_SEG;
			end
			wpf_pkg::ST_F_SEG: begin
				state_d = (vx_w == 64'sd0 && vy_w == 64'sd0) ? wpf_pkg::ST_EMIT
					: wpf_pkg::ST_F_TS;
			end
			wpf_pkg::ST_F_CS: begin
				cd_req.start = issue;
				cd_req.z     = ts_q;
				if (fin) begin
					state_d = wpf_pkg::ST_F_D1;
				end
			end
			wpf_pkg::ST_F_D1: begin
				md_req.start = issue;
				md_req.a     = 64'(ty_q) - 64'(sy_q);
				md_req.b     = 64'(cd_x >>> 10);
				if (fin) begin
					state_d = wpf_pkg::ST_F_D2;
				end
			end
			wpf_pkg::ST_F_D2: begin
				md_req.start = issue;
				md_req.a     = 64'(tx_q) - 64'(sx_q);
				md_req.b     = 64'(cd_y >>> 10);
				if (fin) begin
					state_d = wpf_pkg::ST_F_ERR;
				end
			end
			wpf_pkg::ST_F_ERR: begin
				cd_req.start = issue;
				cd_req.z     = yawz_w - ts_q;
				if (fin) begin
					state_d = wpf_pkg::ST_F_CHK;
				end
			end
			wpf_pkg::ST_F_CHK: begin
				state_d = (c15_w > -64'sd32 && c15_w < 64'sd32) ? wpf_pkg::ST_EMIT
					: wpf_pkg::ST_F_NUM;
			end
			wpf_pkg::ST_F_NUM: begin
				md_req.start = issue;
				md_req.a     = speed_w;
				md_req.b     = s15_w;
				if (fin) begin
					state_d = wpf_pkg::ST_F_DEN;
				end
			end
			wpf_pkg::ST_F_DEN: begin
				md_req.start = issue;
				md_req.a     = l1_w;
				md_req.b     = c15_w;
				if (fin) begin
					state_d = wpf_pkg::ST_F_DIV;
				end
			end
			wpf_pkg::ST_F_DIV: begin
				md_req.start = issue;
				md_req.div   = 1'b1;
				md_req.a     = num_q;
				md_req.b     = den_q;
				if (fin) begin
					state_d = wpf_pkg::ST_F_T2;
				end
			end
			wpf_pkg::ST_F_T2: begin
				md_req.start = issue;
				md_req.a     = 64'(d_q);
				md_req.b     = speed_w;
				if (fin) begin
					state_d = wpf_pkg::ST_EMIT;
				end
			end
			wpf_pkg::ST_EMIT: begin
				if (!m_valid_q || m_tready) begin
					state_d = wpf_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = wpf_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= wpf_pkg::ST_IDLE;
			go_q      <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cd_req.start || md_req.start) begin
				go_q <= 1'b1;
			end else if (cd_done || md_done) begin
				go_q <= 1'b0;
			end
			if (state_q == wpf_pkg::ST_EMIT && (!m_valid_q || m_tready)) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q <= 31'd65536;
			la_q    <= 31'd32768;
			gain_q  <= 31'd655360;
			lim_q   <= 31'd205887;
			tol_q   <= 15'd410;
			mode_q  <= wpf_pkg::MODE_DONE;
			np_q    <= '0;
			pl_q    <= '0;
			th_q    <= '0;
			sx_q    <= '0;
			sy_q    <= '0;
			ex_q    <= '0;
			ey_q    <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					wpf_pkg::REG_FWD_SPEED: speed_q <= cfg_data;
					wpf_pkg::REG_LOOKAHEAD: la_q    <= cfg_data;
					wpf_pkg::REG_ROT_GAIN:  gain_q  <= cfg_data;
					wpf_pkg::REG_ANG_LIMIT: lim_q   <= cfg_data;
					wpf_pkg::REG_HEAD_TOL:  tol_q   <= cfg_data[14:0];
					default: ;
				endcase
			end
			case (state_q)
				wpf_pkg::ST_IDLE: begin
					if (accept && in_req == wpf_pkg::REQ_START && count_ok) begin
						pl_q   <= PLW'(in_count);
						mode_q <= wpf_pkg::MODE_ROT;
						np_q   <= '0;
					end
				end
				wpf_pkg::ST_START_A: begin
					sx_q <= ram_rdata[31:0];
					sy_q <= ram_rdata[63:32];
				end
				wpf_pkg::ST_START_B: begin
					ex_q <= ram_rdata[31:0];
					ey_q <= ram_rdata[63:32];
				end
				wpf_pkg::ST_HEAD: begin
					if (fin) begin
						th_q <= 16'(hz_w >>> 18);
					end
				end
				wpf_pkg::ST_ROT: begin
					if (aerr_w < 17'sd0 + $signed({2'b0, tol_q})) begin
						if (np_q == '0) begin
							mode_q <= wpf_pkg::MODE_FOLLOW;
							np_q   <= NPW'(1);
						end else begin
							mode_q <= wpf_pkg::MODE_DONE;
						end
					end
				end
				wpf_pkg::ST_F_DECIDE: begin
					if (dot_pos_q && !last_seg) begin
						sx_q <= ex_q;
						sy_q <= ey_q;
						np_q <= np_q + NPW'(1);
					end
				end
				wpf_pkg::ST_F_FINAL: begin
					th_q   <= ram_rdata[79:64];
					mode_q <= wpf_pkg::MODE_ROT;
				end
				wpf_pkg::ST_F_ADV: begin
					ex_q <= ram_rdata[31:0];
					ey_q <= ram_rdata[63:32];
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			wpf_pkg::ST_IDLE: begin
				if (accept) begin
					px_q  <= s_tdata[37:6];
					py_q  <= s_tdata[69:38];
					yaw_q <= s_tdata[85:70];
					lin_q <= '0;
					ang_q <= '0;
					ok_q  <= 1'b1;
				end
			end
			wpf_pkg::ST_ROT_MUL: begin
				if (fin) begin
					ang_q <= wpf_pkg::clamp_lim(md_res >>> 12, lim_q);
				end
			end
			wpf_pkg::ST_F_TX: begin
				if (fin) begin
					tx_q <= wpf_pkg::sat32(64'(px_q) + (md_res >>> 30));
				end
			end
			wpf_pkg::ST_F_TY: begin
				if (fin) begin
					ty_q <= wpf_pkg::sat32(64'(py_q) + (md_res >>> 30));
				end
			end
			wpf_pkg::ST_F_DOT1, wpf_pkg::ST_F_D1: begin
				if (fin) begin
					prod_q <= md_res;
				end
			end
			wpf_pkg::ST_F_DOT2: begin
				if (fin) begin
					dot_pos_q <= (prod_q + md_res) > 64'sd0;
				end
			end
			wpf_pkg::ST_F_SEG: begin
				lin_q <= speed_q;
				if (vx_w == 64'sd0 && vy_w == 64'sd0) begin
					ok_q <= 1'b0;
				end
			end
			wpf_pkg::ST_F_TS: begin
				if (fin) begin
					ts_q <= cd_z;
				end
			end
			wpf_pkg::ST_F_D2: begin
				if (fin) begin
					d_q <= wpf_pkg::sat32((prod_q - md_res) >>> 20);
				end
			end
			wpf_pkg::ST_F_CHK: begin
				if (c15_w > -64'sd32 && c15_w < 64'sd32) begin
					ok_q <= 1'b0;
				end
			end
			wpf_pkg::ST_F_NUM: begin
				if (fin) begin
					num_q <= md_res <<< 16;
				end
			end
			wpf_pkg::ST_F_DEN: begin
				if (fin) begin
					den_q <= md_res;
				end
			end
			wpf_pkg::ST_F_DIV: begin
				if (fin) begin
					t1_q <= md_res;
				end
			end
			wpf_pkg::ST_F_T2: begin
				if (fin) begin
					ang_q <= wpf_pkg::clamp_lim(ang_raw, lim_q);
				end
			end
			wpf_pkg::ST_EMIT: begin
				if (!m_valid_q || m_tready) begin
					out_q <= {7'd0, 6'(np_q), (mode_q == wpf_pkg::MODE_DONE), mode_q,
						ok_q, ang_q, lin_q};
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = out_q;
endmodule

// File: dv/waypoint_path_follower_core_tb.sv
`timescale 1ns/1ps
module waypoint_path_follower_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import wpf_pkg::*;

	localparam int NPTS = 64;
	localparam int NSTEPS = 16;
	localparam longint PI_Q30 = 64'sd3373259426;
	localparam longint HALF_PI_Q30 = 64'sd1686629713;
	localparam longint TWO_PI_Q30 = 64'sd6746518852;
	localparam longint GAIN_Q30 = 64'sd652032874;
	localparam longint I32_MIN = -64'sd2147483648;
	localparam longint I32_MAX = 64'sd2147483647;
	localparam int LONG_HOLD = 400;

	typedef struct packed {
		logic [6:0]  count;
		logic [15:0] yaw;
		logic [31:0] py;
		logic [31:0] px;
		logic [5:0]  slot;
	} pose_t;

	typedef struct {
		logic [1:0] kind;
		pose_t      body;
	} request_t;

	typedef struct packed {
		logic [5:0]  idx;
		logic        goal;
		logic [1:0]  mode;
		logic        ok;
		logic [31:0] ang;
		logic [30:0] lin;
	} command_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [95:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [79:0] m_tdata;
	logic        cfg_we;
	logic [2:0]  cfg_addr;
	logic [30:0] cfg_data;

	waypoint_path_follower_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// Predictor state.
	longint arc_tab [NSTEPS] = '{843314857, 497837830, 263043837, 133525159, 67021688,
		33543515, 16775850, 8388438, 4194283, 2097150, 1048576, 524288, 262144, 131072,
		65536, 32768};
	longint way_x [NPTS];
	longint way_y [NPTS];
	longint way_yaw [NPTS];
	longint seg_sx, seg_sy, seg_ex, seg_ey, aim_heading;
	mode_t  plan_mode;
	int     cur_point, plan_len;
	longint speed_reg, look_reg, gain_reg, limit_reg, tol_reg;

	request_t pending [$];
	command_t expected_cmds [$];
	int       mismatches;
	int       checked;
	int       mode_seen [3];
	int       plans_run;
	bit       fast_send;
	int       long_req;
	int       long_done;
	bit       took_req;
	bit       took_cmd;
	int       send_gap;
	int       stall_left;

	function automatic longint clampv(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic void rotate_vec(input longint z0, output longint c, output longint s);
		longint x, y, z, dx, dy;
		bit flip;
		x = GAIN_Q30;
		y = 0;
		z = z0;
		flip = 0;
		while (z > PI_Q30) z -= TWO_PI_Q30;
		while (z < -PI_Q30) z += TWO_PI_Q30;
		if (z > HALF_PI_Q30) begin
			z -= PI_Q30;
			flip = 1;
		end else if (z < -HALF_PI_Q30) begin
			z += PI_Q30;
			flip = 1;
		end
		for (int i = 0; i < NSTEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= arc_tab[i];
			end else begin
				x += dx; y -= dy; z += arc_tab[i];
			end
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endfunction

	function automatic longint vec_angle(longint vy, longint vx);
		longint x, y, z, dx, dy;
		x = vx;
		y = vy;
		z = 0;
		if (vx < 0) begin
			x = -vx;
			y = -vy;
			z = vy >= 0 ? PI_Q30 : -PI_Q30;
		end
		for (int i = 0; i < NSTEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y > 0) begin
				x += dx; y -= dy; z += arc_tab[i];
			end else begin
				x -= dx; y += dy; z -= arc_tab[i];
			end
		end
		return z;
	endfunction

	function automatic command_t steer(request_t r);
		command_t o;
		longint px, py, yaw, ang, lim, err, l1, cy, sy, tx, ty, vx, vy, dot;
		longint ts, cs, ss, ce, se, d, c15, s15, t1, t2;
		int cnt;
		px = longint'($signed(r.body.px));
		py = longint'($signed(r.body.py));
		yaw = longint'($signed(r.body.yaw));
		cnt = r.body.count;
		ang = 0;
		lim = limit_reg;
		o.lin = '0;
		o.ok = 1'b1;
		if (r.kind == REQ_LOAD) begin
			way_x[r.body.slot] = px;
			way_y[r.body.slot] = py;
			way_yaw[r.body.slot] = yaw;
		end else if (r.kind == REQ_START) begin
			if (cnt >= 2 && cnt <= NPTS) begin
				plan_len = cnt;
				plan_mode = MODE_ROT;
				cur_point = 0;
				seg_sx = way_x[0]; seg_sy = way_y[0];
				seg_ex = way_x[1]; seg_ey = way_y[1];
				aim_heading = longint'(int'((vec_angle(seg_ey - seg_sy, seg_ex - seg_sx)
					+ (64'sd1 <<< 17)) >>> 18));
			end
		end else if (r.kind == REQ_TICK && plan_mode == MODE_ROT) begin
			err = aim_heading - yaw;
			if ((err < 0 ? -err : err) < tol_reg) begin
				plan_mode = (cur_point == 0) ? MODE_FOLLOW : MODE_DONE;
				if (cur_point == 0) cur_point = 1;
			end else begin
				ang = clampv((gain_reg * err) >>> 12, -lim, lim);
			end
		end else if (r.kind == REQ_TICK && plan_mode == MODE_FOLLOW) begin
			l1 = look_reg != 0 ? look_reg : 1;
			rotate_vec(yaw * 262144, cy, sy);
			tx = clampv(px + ((l1 * cy) >>> 30), I32_MIN, I32_MAX);
			ty = clampv(py + ((l1 * sy) >>> 30), I32_MIN, I32_MAX);
			vx = seg_ex - seg_sx;
			vy = seg_ey - seg_sy;
			dot = (vx >>> 3) * ((tx - seg_ex) >>> 3) + (vy >>> 3) * ((ty - seg_ey) >>> 3);
			if (dot > 0 && !(cur_point + 1 < plan_len)) begin
				aim_heading = way_yaw[cur_point];
				plan_mode = MODE_ROT;
			end else begin
				if (dot > 0) begin
					seg_sx = seg_ex; seg_sy = seg_ey;
					cur_point++;
					seg_ex = way_x[cur_point];
					seg_ey = way_y[cur_point];
				end
				o.lin = speed_reg[30:0];
				vx = seg_ex - seg_sx;
				vy = seg_ey - seg_sy;
				if (vx == 0 && vy == 0) begin
					o.ok = 1'b0;
				end else begin
					ts = vec_angle(vy, vx);
					rotate_vec(ts, cs, ss);
					d = ((cs >>> 10) * (ty - seg_sy) - (ss >>> 10) * (tx - seg_sx)) >>> 20;
					d = clampv(d, I32_MIN, I32_MAX);
					rotate_vec(yaw * 262144 - ts, ce, se);
					c15 = ce >>> 15;
					s15 = se >>> 15;
					if (c15 > -32 && c15 < 32) begin
						o.ok = 1'b0;
					end else begin
						t1 = (speed_reg * s15 * 65536) / (c15 * l1);
						t2 = 10 * ((speed_reg * d) >>> 16);
						ang = c15 > 0 ? -t1 - t2 : -t1 + t2;
						ang = clampv(ang, -lim, lim);
					end
				end
			end
		end
		o.ang = ang[31:0];
		o.mode = plan_mode;
		o.goal = plan_mode == MODE_DONE;
		o.idx = cur_point[5:0];
		return o;
	endfunction

	task automatic report_mismatch(string field, longint got, longint want);
		mismatches++;
		$display("[%0t] mismatch on %s: got %0d, expected %0d", $time, field, got, want);
	endtask

	// Request side: predict at the accepting edge, change inputs at the falling edge.
	always @(posedge clk) begin
		took_req <= s_tvalid && s_tready;
		if (s_tvalid && s_tready) begin
			request_t r;
			r.kind = s_tuser;
			r.body = s_tdata[92:0];
			expected_cmds.push_back(steer(r));
		end
	end

	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || took_req)) begin
			if (send_gap > 0 || pending.size() == 0) begin
				s_tvalid <= 1'b0;
				if (send_gap > 0) send_gap <= send_gap - 1;
			end else begin
				request_t r;
				r = pending.pop_front();
				s_tvalid <= 1'b1;
				s_tuser <= r.kind;
				s_tdata <= {3'b000, r.body};
				send_gap <= fast_send ? 0 : $urandom_range(0, 8);
			end
		end
	end

	// Command side.
	always @(posedge clk) begin
		took_cmd <= m_tvalid && m_tready;
		if (m_tvalid && m_tready) begin
			command_t g, w;
			g = m_tdata[72:0];
			checked++;
			if (expected_cmds.size() == 0) begin
				mismatches++;
				$display("[%0t] command with no request outstanding", $time);
			end else begin
				w = expected_cmds.pop_front();
				if (g.mode <= 2) mode_seen[g.mode]++;
				if (g.lin !== w.lin) report_mismatch("linear_rate", g.lin, w.lin);
				if (g.ang !== w.ang)
					report_mismatch("angular_rate", $signed(g.ang), $signed(w.ang));
				if (g.ok !== w.ok) report_mismatch("command_ok", g.ok, w.ok);
				if (g.mode !== w.mode) report_mismatch("mode", g.mode, w.mode);
				if (g.goal !== w.goal) report_mismatch("goal_reached", g.goal, w.goal);
				if (g.idx !== w.idx) report_mismatch("point_index", g.idx, w.idx);
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (long_req > long_done) begin
				long_done <= long_done + 1;
				stall_left <= LONG_HOLD;
				m_tready <= 1'b0;
			end else if (took_cmd) begin
				int n;
				n = fast_send ? 0 : $urandom_range(0, 8);
				stall_left <= n;
				m_tready <= n == 0;
			end else if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				m_tready <= stall_left == 1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	function automatic request_t mk(logic [1:0] k, int slot, longint px, longint py,
		longint yaw, int cnt);
		request_t r;
		r.kind = k;
		r.body.slot = slot[5:0];
		r.body.px = px[31:0];
		r.body.py = py[31:0];
		r.body.yaw = yaw[15:0];
		r.body.count = cnt[6:0];
		return r;
	endfunction

	function automatic longint fix16(real v);
		return clampv(longint'(v * 65536.0), I32_MIN, I32_MAX);
	endfunction

	function automatic longint fix12(real v);
		return clampv(longint'(v * 4096.0), -32768, 32767);
	endfunction

	function automatic real jitter(real a);
		return a * ($urandom_range(0, 2000) - 1000) / 1000.0;
	endfunction

	function automatic request_t noise_req();
		return mk($urandom_range(0, 3), $urandom_range(0, 63), longint'($signed($urandom())),
			longint'($signed($urandom())), $urandom_range(0, 65535) - 32768,
			$urandom_range(0, 127));
	endfunction

	task automatic wait_idle();
		wait (pending.size() == 0 && !s_tvalid && expected_cmds.size() == 0);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, longint v);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_addr = idx;
		cfg_data = v[30:0];
		case (idx)
			REG_FWD_SPEED: speed_reg = v & 32'h7FFFFFFF;
			REG_LOOKAHEAD: look_reg = v & 32'h7FFFFFFF;
			REG_ROT_GAIN:  gain_reg = v & 32'h7FFFFFFF;
			REG_ANG_LIMIT: limit_reg = v & 32'h7FFFFFFF;
			default:       tol_reg = v & 32'h7FFF;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic tune(longint sp, longint la, longint gn, longint lm, longint tl);
		wait_idle();
		write_reg(REG_FWD_SPEED, sp);
		write_reg(REG_LOOKAHEAD, la);
		write_reg(REG_ROT_GAIN, gn);
		write_reg(REG_ANG_LIMIT, lm);
		write_reg(REG_HEAD_TOL, tl);
	endtask

	// One plan walked roughly along its path, with some corrupted requests mixed in.
	task automatic queue_plan(int npts, ref int made);
		real wx [NPTS];
		real wy [NPTS];
		real dir, hd, fx, fy, px, py;
		int steps;
		dir = $urandom_range(0, 6283) / 1000.0 - 3.1415;
		wx[0] = jitter(50.0);
		wy[0] = jitter(50.0);
		for (int k = 1; k < npts; k++) begin
			dir += jitter(1.2);
			wx[k] = wx[k-1] + (1.0 + $urandom_range(0, 2000) / 1000.0) * $cos(dir);
			wy[k] = wy[k-1] + (1.0 + $urandom_range(0, 2000) / 1000.0) * $sin(dir);
		end
		for (int k = 0; k < npts; k++) begin
			pending.push_back(mk(REQ_LOAD, k, fix16(wx[k]), fix16(wy[k]), fix12(jitter(3.1)),
				$urandom_range(0, 127)));
		end
		pending.push_back(mk(REQ_START, $urandom_range(0, 63), 0, 0, 0, npts));
		made += npts + 1;
		hd = $atan2(wy[1] - wy[0], wx[1] - wx[0]);
		pending.push_back(mk(REQ_TICK, 0, fix16(wx[0]), fix16(wy[0]), fix12(hd + jitter(1.5)), 0));
		pending.push_back(mk(REQ_TICK, 0, fix16(wx[0]), fix16(wy[0]), fix12(hd + jitter(0.05)), 0));
		made += 2;
		for (int k = 1; k < npts; k++) begin
			hd = $atan2(wy[k] - wy[k-1], wx[k] - wx[k-1]);
			steps = $urandom_range(2, 6);
			for (int j = 1; j <= steps; j++) begin
				fx = wx[k-1] + (wx[k] - wx[k-1]) * j / steps;
				fy = wy[k-1] + (wy[k] - wy[k-1]) * j / steps;
				px = fx + jitter(0.2);
				py = fy + jitter(0.2);
				if ($urandom_range(0, 19) == 0) pending.push_back(noise_req());
				else pending.push_back(mk(REQ_TICK, 0, fix16(px), fix16(py),
					fix12(hd + jitter(0.3)), 0));
				made++;
			end
		end
		for (int j = 0; j < 2; j++) begin
			pending.push_back(mk(REQ_TICK, 0, fix16(wx[npts-1] + $cos(hd)),
				fix16(wy[npts-1] + $sin(hd)), fix12(hd), 0));
		end
		hd = $signed(way_yaw_of(pending, npts - 1)) / 4096.0;
		pending.push_back(mk(REQ_TICK, 0, 0, 0, fix12(hd + jitter(0.05)), 0));
		pending.push_back(mk(REQ_TICK, 0, 0, 0, fix12(hd), 0));
		made += 4;
		plans_run++;
	endtask

	// Final yaw of a waypoint just queued, read back from the pending loads.
	function automatic logic [15:0] way_yaw_of(ref request_t q [$], input int slot);
		logic [15:0] y;
		y = '0;
		foreach (q[i]) begin
			if (q[i].kind == REQ_LOAD && q[i].body.slot == slot) y = q[i].body.yaw;
		end
		return y;
	endfunction

	initial begin
		int made;
		int phase;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_data = '0;
		mismatches = 0;
		checked = 0;
		plans_run = 0;
		fast_send = 0;
		long_req = 0;
		long_done = 0;
		took_req = 0;
		took_cmd = 0;
		send_gap = 0;
		stall_left = 0;
		mode_seen = '{0, 0, 0};
		seg_sx = 0; seg_sy = 0; seg_ex = 0; seg_ey = 0;
		aim_heading = 0;
		plan_mode = MODE_DONE;
		cur_point = 0;
		plan_len = 0;
		speed_reg = 65536;
		look_reg = 32768;
		gain_reg = 655360;
		limit_reg = 205887;
		tol_reg = 410;
		made = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part: loads to randomly chosen slots first, then edge-case requests.
		for (int k = 0; k < NPTS; k++) pending.push_back(noise_req());
		foreach (pending[i]) pending[i].kind = REQ_LOAD;
		pending.push_back(mk(REQ_TICK, 0, I32_MAX, I32_MIN, 32767, 127));
		pending.push_back(mk(2'd3, 63, I32_MIN, I32_MAX, -32768, 127));
		pending.push_back(mk(REQ_START, 0, 0, 0, 0, 0));
		pending.push_back(mk(REQ_START, 0, 0, 0, 0, 1));
		pending.push_back(mk(REQ_START, 0, 0, 0, 0, 65));
		pending.push_back(mk(REQ_START, 0, 0, 0, 0, 127));
		pending.push_back(mk(REQ_LOAD, 0, 0, 0, 0, 0));
		pending.push_back(mk(REQ_LOAD, 1, 0, 0, 0, 0));
		pending.push_back(mk(REQ_LOAD, 2, 65536, 0, 32767, 0));
		pending.push_back(mk(REQ_START, 0, 0, 0, 0, 3));
		pending.push_back(mk(REQ_TICK, 0, 0, 0, -32768, 0));
		pending.push_back(mk(REQ_TICK, 0, 0, 0, 0, 0));
		pending.push_back(mk(REQ_TICK, 0, 0, 0, 0, 0));
		pending.push_back(mk(REQ_TICK, 0, I32_MAX, I32_MAX, 6434, 0));
		pending.push_back(mk(REQ_TICK, 0, I32_MIN, I32_MIN, 0, 0));
		pending.push_back(mk(REQ_START, 0, 0, 0, 0, 64));
		pending.push_back(mk(REQ_TICK, 0, 0, 0, 0, 0));
		made += NPTS + 17;
		tune(64'h7FFFFFFF, 0, 64'h7FFFFFFF, 64'h7FFFFFFF, 64'h7FFF);
		pending.push_back(mk(REQ_START, 0, 0, 0, 0, 2));
		pending.push_back(mk(REQ_TICK, 0, 0, 0, 0, 0));
		pending.push_back(mk(REQ_TICK, 0, 100, -100, 6000, 0));
		pending.push_back(mk(REQ_TICK, 0, 0, 0, 32767, 0));
		made += 4;
		queue_plan(2, made);
		tune(0, 64'h7FFFFFFF, 0, 0, 0);
		queue_plan(3, made);

		// Random part, with the registers retuned between phases.
		phase = 0;
		while (made < 1600) begin
			if (phase % 5 == 4) begin
				tune($urandom_range(0, 32'h7FFFFFFF), $urandom_range(0, 32'h7FFFFFFF),
					$urandom_range(0, 32'h7FFFFFFF), $urandom_range(0, 32'h7FFFFFFF),
					$urandom_range(0, 32767));
			end else begin
				tune($urandom_range(6554, 196608), $urandom_range(13107, 65536),
					$urandom_range(65536, 1310720), $urandom_range(32768, 400000),
					$urandom_range(100, 800));
			end
			fast_send = phase % 4 == 1;
			if (phase == 2) long_req = long_req + 1;
			for (int p = 0; p < 4; p++) begin
				queue_plan($urandom_range(0, 9) == 0 ? $urandom_range(10, NPTS)
					: $urandom_range(2, 6), made);
				repeat ($urandom_range(0, 4)) begin
					pending.push_back(noise_req());
					made++;
				end
			end
			phase++;
		end

		wait_idle();
		repeat (600) @(posedge clk);
		$display("Ran %0d plans over %0d commands (rotating %0d, following %0d, done %0d).",
			plans_run, checked, mode_seen[0], mode_seen[1], mode_seen[2]);
		$display("Register settings included zero and full-scale values.");
		if (mismatches == 0 && expected_cmds.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	initial begin
		#40_000_000;
		$display("Timed out with %0d commands outstanding.", expected_cmds.size());
		$display("Verification failed");
		$finish;
	end

endmodule
